// ----- src/sha_pkg.sv -----
package sha_pkg;

	localparam int BLOCK_WORDS = 16;
	localparam int ROUNDS = 64;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_START = 6'd56;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		ror = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		big_s0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		big_s1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

	function automatic logic [31:0] small_s0(input logic [31:0] x);
		small_s0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] x);
		small_s1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ----- src/sha_ram.sv -----
module sha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ----- src/sha256_message_hasher.sv -----
// one item per cycle while a block fills; a byte that completes a 64-byte block
// stalls input while the block is loaded from the word ram, run through the rounds and added
// end of message: padding bytes plus one or two compressions, then eight
// digest words, one per output transfer; input is held off until word 7 is taken
// arst_n puts the chaining state at the initial hash values with empty block and length
module sha256_message_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PAD80  = 3'd1;
	localparam logic [2:0] S_PADZ   = 3'd2;
	localparam logic [2:0] S_PADLEN = 3'd3;
	localparam logic [2:0] S_LOAD   = 3'd4;
	localparam logic [2:0] S_ROUND  = 3'd5;
	localparam logic [2:0] S_ADD    = 3'd6;
	localparam logic [2:0] S_OUT    = 3'd7;

	logic [2:0]  state_q;
	logic [5:0]  fill_q;
	logic [60:0] len_q;
	logic [63:0] len_sh_q;
	logic [23:0] acc_q;
	logic        eom_pend_q, pad_q, done_q;
	logic [6:0]  cnt_q;
	logic [2:0]  idx_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [BLOCK_WORDS];

	logic        wr_en;
	logic [7:0]  wr_byte;
	logic        ram_we;
	logic [31:0] ram_rdata;
	logic [31:0] t1, t2, w_new;
	logic        in_xfer, out_xfer;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign in_xfer   = in_valid && in_ready;
	assign out_xfer  = out_valid && out_ready;

	assign digest_word = h_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'd7);

	// byte path shared by message bytes and padding
	always_comb begin
		wr_en = 1'b0;
		wr_byte = 8'h00;
		unique case (state_q)
			S_IDLE: begin
				wr_en = in_xfer && has_byte;
				wr_byte = data_byte;
			end
			S_PAD80: begin
				wr_en = 1'b1;
				wr_byte = PAD_BYTE;
			end
			S_PADZ: wr_en = (fill_q != LEN_START);
			S_PADLEN: begin
				wr_en = 1'b1;
				wr_byte = len_sh_q[63:56];
			end
			default: ;
		endcase
	end

	assign ram_we = wr_en && (fill_q[1:0] == 2'd3);

	sha_ram #(.WIDTH(32), .DEPTH(BLOCK_WORDS)) u_block_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fill_q[5:2]),
		.wdata({acc_q, wr_byte}),
		.raddr(cnt_q[3:0]),
		.rdata(ram_rdata)
	);

	always_comb begin
		t1 = v_q[7] + big_s1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ ROUND_K[cnt_q[5:0]] + w_q[0];
		t2 = big_s0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = w_q[0] + small_s0(w_q[1]) + w_q[9] + small_s1(w_q[14]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			len_q <= '0;
			eom_pend_q <= 1'b0;
			pad_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
			for (int i = 0; i < 8; i++)
				h_q[i] <= INIT_H[i];
		end else begin
			if (wr_en) begin
				fill_q <= fill_q + 6'd1;
				if (fill_q == 6'd63)
					cnt_q <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						eom_pend_q <= end_of_message;
						if (has_byte)
							len_q <= len_q + 61'd1;
						if (has_byte && fill_q == 6'd63)
							state_q <= S_LOAD;
						else if (end_of_message)
							state_q <= S_PAD80;
					end
				end
				S_PAD80: begin
					pad_q <= 1'b1;
					state_q <= (fill_q == 6'd63) ? S_LOAD : S_PADZ;
				end
				S_PADZ: begin
					if (fill_q == LEN_START)
						state_q <= S_PADLEN;
					else if (fill_q == 6'd63)
						state_q <= S_LOAD;
				end
				S_PADLEN: begin
					if (fill_q == 6'd63) begin
						done_q <= 1'b1;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (cnt_q == 7'd16) begin
						cnt_q <= '0;
						state_q <= S_ROUND;
					end else
						cnt_q <= cnt_q + 7'd1;
				end
				S_ROUND: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(ROUNDS - 1))
						state_q <= S_ADD;
				end
				S_ADD: begin
					for (int i = 0; i < 8; i++)
						h_q[i] <= h_q[i] + v_q[i];
					if (done_q)
						state_q <= S_OUT;
					else if (pad_q)
						state_q <= S_PADZ;
					else if (eom_pend_q)
						state_q <= S_PAD80;
					else
						state_q <= S_IDLE;
				end
				S_OUT: begin
					if (out_xfer) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							for (int i = 0; i < 8; i++)
								h_q[i] <= INIT_H[i];
							fill_q <= '0;
							len_q <= '0;
							eom_pend_q <= 1'b0;
							pad_q <= 1'b0;
							done_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (wr_en)
			acc_q <= {acc_q[15:0], wr_byte};
		if (state_q == S_PADZ && fill_q == LEN_START)
			len_sh_q <= {len_q, 3'b000};
		else if (state_q == S_PADLEN)
			len_sh_q <= {len_sh_q[55:0], 8'h00};
		if (state_q == S_LOAD && cnt_q != 7'd0) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++)
				w_q[i] <= w_q[i + 1];
			w_q[BLOCK_WORDS - 1] <= ram_rdata;
		end
		if (state_q == S_LOAD && cnt_q == 7'd16) begin
			for (int i = 0; i < 8; i++)
				v_q[i] <= h_q[i];
		end
		if (state_q == S_ROUND) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++)
				w_q[i] <= w_q[i + 1];
			w_q[BLOCK_WORDS - 1] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while digest pending");

	a_len_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PADLEN) |-> (fill_q >= LEN_START))
		else $error("length bytes outside block tail");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && last_word) |=> (in_ready && fill_q == 6'd0 && len_q == 61'd0))
		else $error("hasher not cleared after digest");
endmodule
